[rtl/rac_pkg.sv]
`default_nettype none

package rac_pkg;

    localparam int OPCODE_WIDTH = 3;

    typedef logic [OPCODE_WIDTH-1:0] opcode_t;

    localparam opcode_t OP_LOAD = 3'd0;
    localparam opcode_t OP_ADD  = 3'd1;
    localparam opcode_t OP_SUB  = 3'd2;
    localparam opcode_t OP_MUL  = 3'd3;
    localparam opcode_t OP_DIV  = 3'd4;
    localparam opcode_t OP_READ = 3'd5;

endpackage

`default_nettype wire

[rtl/rac_cmd_if.sv]
`default_nettype none

interface rac_cmd_if #(
    parameter int OPERAND_WIDTH = 16
);
    import rac_pkg::*;

    logic                            valid;
    logic                            ready;
    opcode_t                         opcode;
    logic signed [OPERAND_WIDTH-1:0] operand_num;
    logic signed [OPERAND_WIDTH-1:0] operand_den;

    modport source (output valid, output opcode, output operand_num, output operand_den,
                    input ready);
    modport sink   (input valid, input opcode, input operand_num, input operand_den,
                    output ready);
endinterface

`default_nettype wire

[rtl/rac_rsp_if.sv]
`default_nettype none

interface rac_rsp_if #(
    parameter int ACC_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [ACC_WIDTH-1:0] result_num;
    logic signed [ACC_WIDTH-1:0] result_den;

    modport source (output valid, output result_num, output result_den, input ready);
    modport sink   (input valid, input result_num, input result_den, output ready);
endinterface

`default_nettype wire

[rtl/rac_mul.sv]
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, product wraps at XW bits.
// The multiplier y is two's complement: its top bit weighs negative.
module rac_mul #(
    parameter int XW = 32,
    parameter int YW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [XW-1:0] x,
    input  wire logic [YW-1:0] y,
    output logic               done,
    output logic [XW-1:0]      prod
);
    localparam int CW = $clog2(YW);

    logic [XW-1:0] xs_reg, xs_next;
    logic [YW-1:0] ys_reg, ys_next;
    logic [XW-1:0] p_reg, p_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [XW-1:0] addend;
    logic          last;

    always_comb
    begin
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        addend    = ys_reg[0] ? xs_reg : '0;
        last      = (cnt_reg == CW'(YW - 1));
        if (start)
        begin
            xs_next   = x;
            ys_next   = y;
            p_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = last ? (p_reg - addend) : (p_reg + addend);
            xs_next  = {xs_reg[XW-2:0], 1'b0};
            ys_next  = {1'b0, ys_reg[YW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg <= xs_next;
        ys_reg <= ys_next;
        p_reg  <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

`default_nettype wire

[rtl/rac_reduce.sv]
`default_nettype none

// Reduces two nonzero magnitudes by their GCD.
// Binary GCD (one shift or subtract per cycle), then a restoring divide of
// both terms by the GCD in parallel, one quotient bit per cycle.
module rac_reduce #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] n_in,
    input  wire logic [WIDTH-1:0] d_in,
    output logic                  done,
    output logic [WIDTH-1:0]      n_out,
    output logic [WIDTH-1:0]      d_out
);
    localparam int KW = $clog2(WIDTH + 1);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_TWOS = 2'd1;
    localparam logic [1:0] R_GCD  = 2'd2;
    localparam logic [1:0] R_DIV  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [WIDTH-1:0] u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [WIDTH-1:0] n_reg, n_next, d_reg, d_next;
    logic [WIDTH-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [KW-1:0]    k_reg, k_next, cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial_n, trial_d, diff_n, diff_d;

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        g_next     = g_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        trial_n    = {rn_reg, n_reg[WIDTH-1]};
        trial_d    = {rd_reg, d_reg[WIDTH-1]};
        diff_n     = trial_n - {1'b0, g_reg};
        diff_d     = trial_d - {1'b0, g_reg};
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    u_next     = n_in;
                    v_next     = d_in;
                    n_next     = n_in;
                    d_next     = d_in;
                    k_next     = '0;
                    state_next = R_TWOS;
                end
            end
            R_TWOS:
            begin
                // strip common factors of two
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = R_GCD;
                end
            end
            R_GCD:
            begin
                if (v_reg == '0)
                begin
                    g_next     = u_reg << k_reg;
                    rn_next    = '0;
                    rd_next    = '0;
                    cnt_next   = '0;
                    state_next = R_DIV;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg > v_reg)
                begin
                    u_next = v_reg;
                    v_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            R_DIV:
            begin
                if (!diff_n[WIDTH])
                begin
                    rn_next = diff_n[WIDTH-1:0];
                end
                else
                begin
                    rn_next = trial_n[WIDTH-1:0];
                end
                if (!diff_d[WIDTH])
                begin
                    rd_next = diff_d[WIDTH-1:0];
                end
                else
                begin
                    rd_next = trial_d[WIDTH-1:0];
                end
                n_next   = {n_reg[WIDTH-2:0], ~diff_n[WIDTH]};
                d_next   = {d_reg[WIDTH-2:0], ~diff_d[WIDTH]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == KW'(WIDTH - 1))
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg  <= u_next;
        v_reg  <= v_next;
        g_reg  <= g_next;
        n_reg  <= n_next;
        d_reg  <= d_next;
        rn_reg <= rn_next;
        rd_reg <= rd_next;
    end

    assign done  = done_reg;
    assign n_out = n_reg;
    assign d_out = d_reg;

endmodule

`default_nettype wire

[rtl/rational_accumulator_alu_unit.sv]
// Rational accumulator ALU.
// Holds one fraction acc_num/acc_den. Each request on cmd carries an opcode
// (load, add, subtract, multiply, divide, read) and an operand fraction.
// The operand is first reduced to lowest terms, then combined with the
// accumulator by cross multiplication (load copies it), and the new value is
// reduced again. Reduction works on magnitudes and keeps each term's sign;
// a fraction with a zero term is left as is. Arithmetic wraps at ACC_WIDTH
// bits. Only read produces a response on rsp: the accumulator's two terms.
// Opcodes six and seven are taken and dropped.
// Latency: read shows on rsp one cycle after it is taken. Other requests
// run on one shift-add multiplier (two products for multiply and divide,
// three for add and subtract, none for load) and one GCD/divide unit
// (binary GCD, then a divide of both W-bit magnitudes, W = max of both
// widths), used for the operand and for the result; zero terms skip
// the matching reduction.
// One request is worked on at a time; cmd.ready is low meanwhile.
// A waiting response that rsp does not take also holds off cmd.
// Reset clears the accumulator to 0/0 and drops any pending response.
`default_nettype none

module rational_accumulator_alu_unit #(
    parameter int OPERAND_WIDTH = 16,
    parameter int ACC_WIDTH     = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    rac_cmd_if.sink  cmd,
    rac_rsp_if.source rsp
);
    import rac_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int AW = ACC_WIDTH;
    localparam int MW = (OPERAND_WIDTH > ACC_WIDTH) ? OPERAND_WIDTH : ACC_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OPCHK  = 4'd1;
    localparam logic [3:0] S_OPRED  = 4'd2;
    localparam logic [3:0] S_ARITH  = 4'd3;
    localparam logic [3:0] S_MUL0   = 4'd4;
    localparam logic [3:0] S_MUL1   = 4'd5;
    localparam logic [3:0] S_MUL2   = 4'd6;
    localparam logic [3:0] S_ACCCHK = 4'd7;
    localparam logic [3:0] S_ACCRED = 4'd8;

    logic [3:0]    state_reg, state_next;
    opcode_t       op_reg, op_next;
    logic [OW-1:0] cn_reg, cn_next, cd_reg, cd_next;
    logic [AW-1:0] nn_reg, nn_next, nd_reg, nd_next;
    logic [AW-1:0] acc_num_reg, acc_num_next, acc_den_reg, acc_den_next;
    logic          mul_start_reg, mul_start_next;
    logic          red_start_reg, red_start_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [AW-1:0] out_num_reg, out_num_next, out_den_reg, out_den_next;

    logic          cmd_fire;
    logic          is_add_sub;

    // sign and magnitude views
    logic          cn_neg, cd_neg, nn_neg, nd_neg;
    logic [OW-1:0] cn_mag, cd_mag;
    logic [AW-1:0] nn_mag, nd_mag;
    logic [OW-1:0] cn_q, cd_q;
    logic [AW-1:0] nn_q, nd_q;

    // shared units
    logic [AW-1:0] mul_x, mul_prod;
    logic [OW-1:0] mul_y;
    logic          mul_done;
    logic [MW-1:0] red_n, red_d, red_qn, red_qd;
    logic          red_done;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign is_add_sub = (op_reg == OP_ADD) || (op_reg == OP_SUB);

    assign cn_neg = cn_reg[OW-1];
    assign cd_neg = cd_reg[OW-1];
    assign nn_neg = nn_reg[AW-1];
    assign nd_neg = nd_reg[AW-1];
    assign cn_mag = cn_neg ? (-cn_reg) : cn_reg;
    assign cd_mag = cd_neg ? (-cd_reg) : cd_reg;
    assign nn_mag = nn_neg ? (-nn_reg) : nn_reg;
    assign nd_mag = nd_neg ? (-nd_reg) : nd_reg;

    assign cn_q = cn_neg ? (-red_qn[OW-1:0]) : red_qn[OW-1:0];
    assign cd_q = cd_neg ? (-red_qd[OW-1:0]) : red_qd[OW-1:0];
    assign nn_q = nn_neg ? (-red_qn[AW-1:0]) : red_qn[AW-1:0];
    assign nd_q = nd_neg ? (-red_qd[AW-1:0]) : red_qd[AW-1:0];

    // reduce unit input follows the phase: operand or new accumulator value
    assign red_n = (state_reg == S_OPRED) ? MW'(cn_mag) : MW'(nn_mag);
    assign red_d = (state_reg == S_OPRED) ? MW'(cd_mag) : MW'(nd_mag);

    // multiplier operands by product slot
    //   slot 0: a*d (a*c for multiply)
    //   slot 1: b*c (add and subtract only)
    //   slot 2: b*d (b*c for divide)
    always_comb
    begin
        mul_x = acc_den_reg;
        mul_y = cd_reg;
        case (state_reg)
            S_MUL0:
            begin
                mul_x = acc_num_reg;
                mul_y = (op_reg == OP_MUL) ? cn_reg : cd_reg;
            end
            S_MUL1:
            begin
                mul_y = cn_reg;
            end
            S_MUL2:
            begin
                mul_y = (op_reg == OP_DIV) ? cn_reg : cd_reg;
            end
            default:
            begin
                mul_y = cd_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cn_next        = cn_reg;
        cd_next        = cd_reg;
        nn_next        = nn_reg;
        nd_next        = nd_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        mul_start_next = 1'b0;
        red_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next = cmd.opcode;
                    cn_next = cmd.operand_num;
                    cd_next = cmd.operand_den;
                    if (cmd.opcode == OP_READ)
                    begin
                        out_valid_next = 1'b1;
                        out_num_next   = acc_num_reg;
                        out_den_next   = acc_den_reg;
                    end
                    else if (cmd.opcode inside {[OP_LOAD:OP_DIV]})
                    begin
                        state_next = S_OPCHK;
                    end
                end
            end
            S_OPCHK:
            begin
                if ((cn_reg == '0) || (cd_reg == '0))
                begin
                    state_next = S_ARITH;
                end
                else
                begin
                    red_start_next = 1'b1;
                    state_next     = S_OPRED;
                end
            end
            S_OPRED:
            begin
                if (red_done)
                begin
                    cn_next    = cn_q;
                    cd_next    = cd_q;
                    state_next = S_ARITH;
                end
            end
            S_ARITH:
            begin
                if (op_reg == OP_LOAD)
                begin
                    nn_next    = AW'($signed(cn_reg));
                    nd_next    = AW'($signed(cd_reg));
                    state_next = S_ACCCHK;
                end
                else
                begin
                    mul_start_next = 1'b1;
                    state_next     = S_MUL0;
                end
            end
            S_MUL0:
            begin
                if (mul_done)
                begin
                    nn_next        = mul_prod;
                    mul_start_next = 1'b1;
                    state_next     = is_add_sub ? S_MUL1 : S_MUL2;
                end
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    nn_next        = (op_reg == OP_ADD) ? (nn_reg + mul_prod)
                                                        : (nn_reg - mul_prod);
                    mul_start_next = 1'b1;
                    state_next     = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    nd_next    = mul_prod;
                    state_next = S_ACCCHK;
                end
            end
            S_ACCCHK:
            begin
                if ((nn_reg == '0) || (nd_reg == '0))
                begin
                    acc_num_next = nn_reg;
                    acc_den_next = nd_reg;
                    state_next   = S_IDLE;
                end
                else
                begin
                    red_start_next = 1'b1;
                    state_next     = S_ACCRED;
                end
            end
            S_ACCRED:
            begin
                if (red_done)
                begin
                    acc_num_next = nn_q;
                    acc_den_next = nd_q;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_num_reg   <= '0;
            acc_den_reg   <= '0;
            mul_start_reg <= 1'b0;
            red_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            mul_start_reg <= mul_start_next;
            red_start_reg <= red_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cn_reg      <= cn_next;
        cd_reg      <= cd_next;
        nn_reg      <= nn_next;
        nd_reg      <= nd_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
    end

    rac_mul #(
        .XW (AW),
        .YW (OW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rac_reduce #(
        .WIDTH (MW)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start_reg),
        .n_in  (red_n),
        .d_in  (red_d),
        .done  (red_done),
        .n_out (red_qn),
        .d_out (red_qd)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.result_num = out_num_reg;
    assign rsp.result_den = out_den_reg;

endmodule

`default_nettype wire
